/* sv/assert_macros.svh */
// assertion macros used by the core rtl file
// no dependencies; checks compile away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/pfrs_pkg.sv */
// types and constants for the per-flow receive statistics block
// no dependencies
`timescale 1ns / 1ps
package pfrs_pkg;

  // item operations
  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_MUL, S_ADD, S_DIV,
    S_REC_WR, S_FULL, S_Q_END, S_CLEAR
  } state_t;

  localparam int MAX_REPORTS = 16;
  localparam logic [15:0] SENDER_ANY = 16'd0;
  localparam logic signed [7:0] FLOW_ANY = -8'sd1;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // one table entry as stored in memory
  typedef struct packed {
    logic [15:0]       src;
    logic signed [7:0] flow;
    logic [31:0]       cnt;
    logic [31:0]       mean;
    logic [31:0]       last;
  } ent_t;

endpackage

/* sv/pfrs_if.sv */
// valid/ready channel interfaces for items and results
// depends on nothing but the field widths of the block
`timescale 1ns / 1ps
interface pfrs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [15:0]       sender_addr;
  logic signed [7:0] flow_id;
  logic [31:0]       time_now;
  modport source (output valid, operation, sender_addr, flow_id, time_now, input ready);
  modport sink (input valid, operation, sender_addr, flow_id, time_now, output ready);
endinterface

interface pfrs_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [15:0]       entry_sender;
  logic signed [7:0] entry_flow;
  logic [31:0]       packet_count;
  logic [31:0]       mean_interval;
  logic              last_result;
  modport source (output valid, status, entry_sender, entry_flow, packet_count,
                  mean_interval, last_result, input ready);
  modport sink (input valid, status, entry_sender, entry_flow, packet_count,
                mean_interval, last_result, output ready);
endinterface

/* sv/per_flow_receive_statistics_core.sv */
// Per-flow receive statistics table. Items carry an operation: record a packet,
// query statistics, or clear the table. One item is processed at a time; a
// sequencer walks the table entry by entry, skipping a free entry and reading
// a valid one before comparing it. A record that hits then runs a multiply,
// an add and a bit-serial divide for the running mean; a miss or a query ends
// with the walk, and a clear does not walk the table. Query results leave one
// per transfer, the last flagged with last_result; at most 16 are reported.
// An output register lets the next item enter while a result waits.
// Depends on pfrs_pkg, pfrs_if, pfrs_mem, pfrs_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module per_flow_receive_statistics_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input logic         clk,
  input logic         rst_n,
  pfrs_in_if.sink     in_ch,
  pfrs_out_if.source  out_ch
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int MCNT_W = $clog2(pfrs_pkg::MAX_REPORTS + 1);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [MCNT_W-1:0] MCNT_MAX = MCNT_W'(pfrs_pkg::MAX_REPORTS);

  pfrs_pkg::state_t state_r, state_nxt;
  pfrs_pkg::op_t    op_r, op_nxt;
  logic [15:0]        snd_r, snd_nxt;
  logic signed [7:0]  flow_r, flow_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   free_r, free_nxt;
  logic               free_v_r, free_v_nxt;
  logic [IDX_W-1:0]   hit_r, hit_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  pfrs_pkg::ent_t     ent_r, ent_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [MCNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic [31:0]        k_r, k_nxt;
  logic [63:0]        prod_r, prod_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         o_status_r, o_status_nxt;
  logic [15:0]        o_sender_r, o_sender_nxt;
  logic signed [7:0]  o_flow_r, o_flow_nxt;
  logic [31:0]        o_count_r, o_count_nxt;
  logic [31:0]        o_mean_r, o_mean_nxt;
  logic               o_last_r, o_last_nxt;

  logic           in_fire, out_free, load_out;
  logic           rd_en, mem_we;
  logic [IDX_W-1:0] mem_waddr;
  pfrs_pkg::ent_t rd_ent, mem_wdata;
  logic           div_start, div_busy, div_done;
  logic [63:0]    div_dividend;
  logic [31:0]    div_quotient;
  logic           rec_match, q_match, is_last;
  logic [31:0]    n_cnt, k_val;

  pfrs_mem #(.DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(rd_en), .raddr(idx_r), .rdata(rd_ent)
  );

  pfrs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(k_r), .busy(div_busy), .done(div_done), .quotient(div_quotient)
  );

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == pfrs_pkg::S_IDLE);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign is_last      = (idx_r == IDX_LAST);

  // entry compare and count update from the read data
  always_comb begin
    rec_match = (rd_ent.src == snd_r) && (rd_ent.flow == flow_r);
    q_match   = ((snd_r == pfrs_pkg::SENDER_ANY) || (rd_ent.src == snd_r)) &&
                ((flow_r == pfrs_pkg::FLOW_ANY) || (rd_ent.flow == flow_r));
    n_cnt     = (rd_ent.cnt == pfrs_pkg::COUNT_MAX) ? rd_ent.cnt : rd_ent.cnt + 32'd1;
    k_val     = (n_cnt == 32'd1 || n_cnt == 32'd0) ? 32'd1 : n_cnt - 32'd1;
  end

  // sequencer: next state, table walk, result loading
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    snd_nxt      = snd_r;
    flow_nxt     = flow_r;
    now_nxt      = now_r;
    idx_nxt      = idx_r;
    free_nxt     = free_r;
    free_v_nxt   = free_v_r;
    hit_nxt      = hit_r;
    valid_nxt    = valid_r;
    ent_nxt      = ent_r;
    pend_v_nxt   = pend_v_r;
    mcnt_nxt     = mcnt_r;
    k_nxt        = k_r;
    prod_nxt     = prod_r;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = hit_r;
    mem_wdata    = ent_r;
    div_start    = 1'b0;
    div_dividend = prod_r + {32'd0, now_r - ent_r.last};
    load_out     = 1'b0;
    o_status_nxt = pfrs_pkg::ST_OK;
    o_sender_nxt = snd_r;
    o_flow_nxt   = flow_r;
    o_count_nxt  = 32'd0;
    o_mean_nxt   = 32'd0;
    o_last_nxt   = 1'b1;

    unique case (state_r)
      pfrs_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt     = pfrs_pkg::op_t'(in_ch.operation);
          snd_nxt    = in_ch.sender_addr;
          flow_nxt   = in_ch.flow_id;
          now_nxt    = in_ch.time_now;
          idx_nxt    = '0;
          free_v_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          mcnt_nxt   = '0;
          unique case (pfrs_pkg::op_t'(in_ch.operation))
            pfrs_pkg::OP_RECORD, pfrs_pkg::OP_QUERY: state_nxt = pfrs_pkg::S_READ;
            pfrs_pkg::OP_CLEAR: begin
              valid_nxt = '0;
              state_nxt = pfrs_pkg::S_CLEAR;
            end
            pfrs_pkg::OP_UNUSED: state_nxt = pfrs_pkg::S_IDLE;
          endcase
        end
      end

      // issue a read for a valid entry, skip a free one
      pfrs_pkg::S_READ: begin
        if (valid_r[idx_r]) begin
          rd_en     = 1'b1;
          state_nxt = pfrs_pkg::S_CHECK;
        end else begin
          if (op_r == pfrs_pkg::OP_RECORD && !free_v_r) begin
            free_nxt   = idx_r;
            free_v_nxt = 1'b1;
          end
          if (!is_last) begin
            idx_nxt = idx_r + 1'b1;
          end else if (op_r == pfrs_pkg::OP_QUERY) begin
            state_nxt = pfrs_pkg::S_Q_END;
          end else if (free_v_nxt) begin
            hit_nxt   = free_nxt;
            ent_nxt   = '{src: snd_r, flow: flow_r, cnt: 32'd1, mean: 32'd0, last: now_r};
            state_nxt = pfrs_pkg::S_REC_WR;
          end else begin
            state_nxt = pfrs_pkg::S_FULL;
          end
        end
      end

      // compare the entry just read
      pfrs_pkg::S_CHECK: begin
        if (op_r == pfrs_pkg::OP_RECORD) begin
          if (rec_match) begin
            ent_nxt     = rd_ent;
            ent_nxt.cnt = n_cnt;
            k_nxt       = k_val;
            hit_nxt     = idx_r;
            state_nxt   = pfrs_pkg::S_MUL;
          end else if (!is_last) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = pfrs_pkg::S_READ;
          end else if (free_v_r) begin
            hit_nxt   = free_r;
            ent_nxt   = '{src: snd_r, flow: flow_r, cnt: 32'd1, mean: 32'd0, last: now_r};
            state_nxt = pfrs_pkg::S_REC_WR;
          end else begin
            state_nxt = pfrs_pkg::S_FULL;
          end
        end else if (q_match) begin
          // hold one match back so the final one can carry last_result
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              load_out     = 1'b1;
              o_sender_nxt = ent_r.src;
              o_flow_nxt   = ent_r.flow;
              o_count_nxt  = ent_r.cnt;
              o_mean_nxt   = ent_r.mean;
              o_last_nxt   = 1'b0;
            end
            ent_nxt    = rd_ent;
            pend_v_nxt = 1'b1;
            mcnt_nxt   = mcnt_r + 1'b1;
            if (mcnt_nxt == MCNT_MAX || is_last) begin
              state_nxt = pfrs_pkg::S_Q_END;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = pfrs_pkg::S_READ;
            end
          end
        end else if (!is_last) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = pfrs_pkg::S_READ;
        end else begin
          state_nxt = pfrs_pkg::S_Q_END;
        end
      end

      // mean times previous interval count
      pfrs_pkg::S_MUL: begin
        prod_nxt  = ent_r.mean * (k_r - 32'd1);
        state_nxt = pfrs_pkg::S_ADD;
      end

      // add the new interval and start the divide
      pfrs_pkg::S_ADD: begin
        div_start = 1'b1;
        state_nxt = pfrs_pkg::S_DIV;
      end

      pfrs_pkg::S_DIV: begin
        if (div_done) begin
          ent_nxt.mean = div_quotient;
          ent_nxt.last = now_r;
          state_nxt    = pfrs_pkg::S_REC_WR;
        end
      end

      // write back the entry and report it
      pfrs_pkg::S_REC_WR: begin
        if (out_free) begin
          mem_we           = 1'b1;
          valid_nxt[hit_r] = 1'b1;
          load_out         = 1'b1;
          o_count_nxt      = ent_r.cnt;
          o_mean_nxt       = ent_r.mean;
          state_nxt        = pfrs_pkg::S_IDLE;
        end
      end

      pfrs_pkg::S_FULL: begin
        if (out_free) begin
          load_out     = 1'b1;
          o_status_nxt = pfrs_pkg::ST_FULL;
          state_nxt    = pfrs_pkg::S_IDLE;
        end
      end

      // final query result: held match or no-match
      pfrs_pkg::S_Q_END: begin
        if (out_free) begin
          load_out = 1'b1;
          if (pend_v_r) begin
            o_sender_nxt = ent_r.src;
            o_flow_nxt   = ent_r.flow;
            o_count_nxt  = ent_r.cnt;
            o_mean_nxt   = ent_r.mean;
          end else begin
            o_status_nxt = pfrs_pkg::ST_NOMATCH;
          end
          state_nxt = pfrs_pkg::S_IDLE;
        end
      end

      pfrs_pkg::S_CLEAR: begin
        if (out_free) begin
          load_out     = 1'b1;
          o_sender_nxt = 16'd0;
          o_flow_nxt   = 8'sd0;
          state_nxt    = pfrs_pkg::S_IDLE;
        end
      end

      default: state_nxt = pfrs_pkg::S_IDLE;
    endcase

    out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfrs_pkg::S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    snd_r    <= snd_nxt;
    flow_r   <= flow_nxt;
    now_r    <= now_nxt;
    idx_r    <= idx_nxt;
    free_r   <= free_nxt;
    free_v_r <= free_v_nxt;
    hit_r    <= hit_nxt;
    ent_r    <= ent_nxt;
    pend_v_r <= pend_v_nxt;
    mcnt_r   <= mcnt_nxt;
    k_r      <= k_nxt;
    prod_r   <= prod_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_status_r <= o_status_nxt;
      o_sender_r <= o_sender_nxt;
      o_flow_r   <= o_flow_nxt;
      o_count_r  <= o_count_nxt;
      o_mean_r   <= o_mean_nxt;
      o_last_r   <= o_last_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.entry_sender  = o_sender_r;
  assign out_ch.entry_flow    = o_flow_r;
  assign out_ch.packet_count  = o_count_r;
  assign out_ch.mean_interval = o_mean_r;
  assign out_ch.last_result   = o_last_r;

  // checks
  `ASSERT_ALWAYS(a_div_start_idle, clk, rst_n, div_start |-> !div_busy)
  `ASSERT_ALWAYS(a_write_reports, clk, rst_n, mem_we |-> load_out)
  `ASSERT_ALWAYS(a_report_bound, clk, rst_n, (state_r != pfrs_pkg::S_IDLE) |-> (mcnt_r <= MCNT_MAX))
  `ASSERT_NEXT(a_clear_empties, clk, rst_n, in_fire && in_ch.operation == pfrs_pkg::OP_CLEAR, valid_r == '0)

endmodule

/* sv/pfrs_mem.sv */
// entry table memory: one write port, one registered read port
// depends on pfrs_pkg for the entry layout
`timescale 1ns / 1ps
module pfrs_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  pfrs_pkg::ent_t    wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output pfrs_pkg::ent_t    rdata
);

  pfrs_pkg::ent_t mem [DEPTH];
  pfrs_pkg::ent_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/pfrs_div.sv */
// iterative restoring divider, one quotient bit per cycle
// caller guarantees the quotient fits in 32 bits; no package use
`timescale 1ns / 1ps
module pfrs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  // one shift-subtract step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, lo_r[31]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      rem_nxt  = dividend[63:32];
      lo_nxt   = dividend[31:0];
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        lo_nxt  = {lo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        lo_nxt  = {lo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = lo_r;

endmodule

/* dv/tb.sv */
// self-checking testbench for per_flow_receive_statistics_core
// depends on pfrs_pkg, pfrs_if and the core rtl
`timescale 1ns / 1ps
module tb;

  localparam int ENTRIES = 16;
  localparam int DIRECTED_ROWS = 22;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfrs_in_if  in_ch ();
  pfrs_out_if out_ch ();

  per_flow_receive_statistics_core #(.TABLE_ENTRIES(ENTRIES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       sender;
    logic signed [7:0] flow;
    logic [31:0]       count;
    logic [31:0]       mean;
    logic              last;
  } stat_res_t;

  typedef struct {
    pfrs_pkg::op_t     op;
    logic [15:0]       sender;
    logic signed [7:0] flow;
    logic [31:0]       stamp;
    bit                typed;
    stat_res_t         res;
  } stim_row_t;

  // shadow table
  bit          tbl_valid [ENTRIES];
  logic [15:0] tbl_src   [ENTRIES];
  logic [7:0]  tbl_flow  [ENTRIES];
  logic [31:0] tbl_cnt   [ENTRIES];
  logic [31:0] tbl_mean  [ENTRIES];
  logic [31:0] tbl_last  [ENTRIES];

  stat_res_t expected_q[$];
  int        fail_count = 0;
  bit        quiet_sink = 1'b0;
  stim_row_t rows[DIRECTED_ROWS];

  // work out the results of one item and update the shadow table
  task automatic update_stats(input pfrs_pkg::op_t op, input logic [15:0] snd,
                              input logic [7:0] flw, input logic [31:0] now);
    int free_slot;
    int hits;
    logic [31:0] gap;
    logic [31:0] n;
    logic [63:0] k;
    logic [63:0] sum;
    stat_res_t r;
    free_slot = -1;
    hits = 0;
    case (op)
      pfrs_pkg::OP_RECORD: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i]) begin
            if (hits == 0 && tbl_src[i] == snd && tbl_flow[i] == flw) begin
              hits = 1;
              gap = now - tbl_last[i];
              n = tbl_cnt[i];
              if (n != pfrs_pkg::COUNT_MAX) n = n + 1;
              k = {32'd0, n} - 64'd1;
              if (k == 0) k = 1;
              sum = {32'd0, tbl_mean[i]} * (k - 64'd1) + {32'd0, gap};
              tbl_mean[i] = 32'(sum / k);
              tbl_cnt[i] = n;
              tbl_last[i] = now;
              r = '{pfrs_pkg::ST_OK, snd, flw, n, tbl_mean[i], 1'b1};
              expected_q.push_back(r);
            end
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hits == 0) begin
          if (free_slot < 0) begin
            r = '{pfrs_pkg::ST_FULL, snd, flw, 32'd0, 32'd0, 1'b1};
          end else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_src[free_slot] = snd;
            tbl_flow[free_slot] = flw;
            tbl_cnt[free_slot] = 32'd1;
            tbl_mean[free_slot] = 32'd0;
            tbl_last[free_slot] = now;
            r = '{pfrs_pkg::ST_OK, snd, flw, 32'd1, 32'd0, 1'b1};
          end
          expected_q.push_back(r);
        end
      end
      pfrs_pkg::OP_QUERY: begin
        for (int i = 0; i < ENTRIES && hits < pfrs_pkg::MAX_REPORTS; i++) begin
          if (tbl_valid[i] && (snd == pfrs_pkg::SENDER_ANY || snd == tbl_src[i]) &&
              (flw == pfrs_pkg::FLOW_ANY || flw == tbl_flow[i])) begin
            r = '{pfrs_pkg::ST_OK, tbl_src[i], tbl_flow[i], tbl_cnt[i], tbl_mean[i],
                  1'b0};
            expected_q.push_back(r);
            hits++;
          end
        end
        if (hits == 0) begin
          r = '{pfrs_pkg::ST_NOMATCH, snd, flw, 32'd0, 32'd0, 1'b1};
          expected_q.push_back(r);
        end else begin
          expected_q[$].last = 1'b1;
        end
      end
      pfrs_pkg::OP_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        r = '{pfrs_pkg::ST_OK, 16'd0, 8'sd0, 32'd0, 32'd0, 1'b1};
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // drive one item and wait for its transfer
  task automatic send_item(input pfrs_pkg::op_t op, input logic [15:0] snd,
                           input logic [7:0] flw, input logic [31:0] now,
                           input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.sender_addr <= snd;
    in_ch.flow_id     <= flw;
    in_ch.time_now    <= now;
    do @(posedge clk); while (!in_ch.ready);
    update_stats(op, snd, flw, now);
  endtask

  // result sink with random stall bursts
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!quiet_sink && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    stat_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result status=%0d sender=%0h", out_ch.status,
               out_ch.entry_sender);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.entry_sender !== want.sender) begin
          $error("entry_sender exp %0h got %0h", want.sender, out_ch.entry_sender);
          fail_count++;
        end
        if (out_ch.entry_flow !== want.flow) begin
          $error("entry_flow exp %0d got %0d", want.flow, out_ch.entry_flow);
          fail_count++;
        end
        if (out_ch.packet_count !== want.count) begin
          $error("packet_count exp %0d got %0d", want.count, out_ch.packet_count);
          fail_count++;
        end
        if (out_ch.mean_interval !== want.mean) begin
          $error("mean_interval exp %0d got %0d", want.mean, out_ch.mean_interval);
          fail_count++;
        end
        if (out_ch.last_result !== want.last) begin
          $error("last_result exp %0b got %0b", want.last, out_ch.last_result);
          fail_count++;
        end
      end
    end
  end

  // directed table: extremes, wildcards, wrap, unused op, clear
  initial begin
    rows[0]  = '{pfrs_pkg::OP_QUERY,  16'h0000, -8'sd1,  32'd0, 1'b1,
                 '{pfrs_pkg::ST_NOMATCH, 16'h0000, -8'sd1, 32'd0, 32'd0, 1'b1}};
    rows[1]  = '{pfrs_pkg::OP_RECORD, 16'hFFFF, 8'sd127, 32'hFFFF_FFF0, 1'b1,
                 '{pfrs_pkg::ST_OK, 16'hFFFF, 8'sd127, 32'd1, 32'd0, 1'b1}};
    rows[2]  = '{pfrs_pkg::OP_RECORD, 16'hFFFF, 8'sd127, 32'h0000_0010, 1'b0, '0};
    rows[3]  = '{pfrs_pkg::OP_RECORD, 16'hFFFF, 8'sd127, 32'h0000_0030, 1'b0, '0};
    rows[4]  = '{pfrs_pkg::OP_RECORD, 16'h0000, -8'sd128, 32'd0, 1'b0, '0};
    rows[5]  = '{pfrs_pkg::OP_RECORD, 16'h0000, -8'sd128, 32'hFFFF_FFFF, 1'b0, '0};
    rows[6]  = '{pfrs_pkg::OP_RECORD, 16'h1234, -8'sd1, 32'd100, 1'b0, '0};
    rows[7]  = '{pfrs_pkg::OP_QUERY,  16'h0000, -8'sd1, 32'd0, 1'b0, '0};
    rows[8]  = '{pfrs_pkg::OP_QUERY,  16'hFFFF, -8'sd1, 32'd0, 1'b0, '0};
    rows[9]  = '{pfrs_pkg::OP_QUERY,  16'h0000, -8'sd128, 32'd0, 1'b0, '0};
    rows[10] = '{pfrs_pkg::OP_QUERY,  16'h1234, 8'sd5, 32'd0, 1'b1,
                 '{pfrs_pkg::ST_NOMATCH, 16'h1234, 8'sd5, 32'd0, 32'd0, 1'b1}};
    rows[11] = '{pfrs_pkg::OP_UNUSED, 16'hAAAA, 8'sd0, 32'd0, 1'b0, '0};
    rows[12] = '{pfrs_pkg::OP_CLEAR,  16'h5555, 8'sd3, 32'd7, 1'b1,
                 '{pfrs_pkg::ST_OK, 16'h0000, 8'sd0, 32'd0, 32'd0, 1'b1}};
    rows[13] = '{pfrs_pkg::OP_QUERY,  16'h0000, -8'sd1, 32'd0, 1'b1,
                 '{pfrs_pkg::ST_NOMATCH, 16'h0000, -8'sd1, 32'd0, 32'd0, 1'b1}};
    for (int i = 14; i < DIRECTED_ROWS; i++) rows[i] = '{pfrs_pkg::OP_RECORD, 16'h0000,
                 8'(i), 32'd0, 1'b0, '0};
  end

  // stimulus
  initial begin
    logic [15:0] snd;
    logic [7:0]  flw;
    logic [31:0] clock_us;
    int          pick;
    in_ch.valid       = 1'b0;
    in_ch.operation   = pfrs_pkg::OP_RECORD;
    in_ch.sender_addr = '0;
    in_ch.flow_id     = '0;
    in_ch.time_now    = '0;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; typed rows check the predictor as well
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(rows[i].op, rows[i].sender, rows[i].flow, rows[i].stamp, 1'b1);
      if (rows[i].typed && expected_q[$] !== rows[i].res) begin
        $error("directed row %0d predictor disagrees with table", i);
        fail_count++;
      end
    end
    // fill the table past full
    for (int i = 0; i < 12; i++) send_item(pfrs_pkg::OP_RECORD, 16'h00F0 + 16'(i),
                                           8'sd9, 32'(i), 1'b1);
    send_item(pfrs_pkg::OP_QUERY, 16'h0000, -8'sd1, 32'd0, 1'b1);

    // random traffic, mostly on a small pool of flows, with mostly advancing time
    clock_us = $urandom;
    for (int n = 0; n < 335; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
        snd = 16'($urandom);
        flw = 8'($urandom);
      end else begin
        snd = 16'($urandom_range(0, 5)) * 16'h3333;
        flw = 8'($urandom_range(0, 4)) - 8'd2;
      end
      clock_us = clock_us + $urandom_range(0, 4000);
      if ($urandom_range(0, 19) == 0) clock_us = $urandom;
      if (pick < 70) begin
        send_item(pfrs_pkg::OP_RECORD, snd, flw, clock_us, n < 290);
      end else if (pick < 93) begin
        if ($urandom_range(0, 1)) snd = pfrs_pkg::SENDER_ANY;
        if ($urandom_range(0, 1)) flw = pfrs_pkg::FLOW_ANY;
        send_item(pfrs_pkg::OP_QUERY, snd, flw, clock_us, n < 290);
      end else if (pick < 97) begin
        send_item(pfrs_pkg::OP_CLEAR, snd, flw, clock_us, n < 290);
      end else begin
        send_item(pfrs_pkg::OP_UNUSED, snd, flw, clock_us, n < 290);
      end
      if (n == 290) quiet_sink = 1'b1;
    end
    in_ch.valid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
